FILE: rtl/ajac_pkg.sv
package ajac_pkg;

  localparam int CordicStepsDef = 16;
  localparam int CordicStepsMax = 24;

  localparam int CordicW = 34;
  localparam logic signed [CordicW-1:0] Q30Pi     = 34'sd3373259426;
  localparam logic signed [CordicW-1:0] Q30HalfPi = 34'sd1686629713;
  localparam logic signed [CordicW-1:0] CordicGain = 34'sd652032874;

  localparam logic [29:0] AtanTab [CordicStepsMax] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
    30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
    30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
    30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256, 30'd128
  };

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] RegUpper     = 2'd0;
  localparam logic [CfgIdxW-1:0] RegLower     = 2'd1;
  localparam logic [CfgIdxW-1:0] RegTranspose = 2'd2;

  localparam logic [15:0] UpperReset = 16'd14090;
  localparam logic [15:0] LowerReset = 16'd11141;

  localparam int EntryW = 18;
  localparam logic signed [23:0] EntryMax = 24'sd131071;
  localparam logic signed [23:0] EntryMin = -24'sd131072;
  localparam logic signed [23:0] QOne = 24'sd65536;

  typedef logic signed [23:0] q16_t;
  typedef logic signed [EntryW-1:0] entry_t;

  function automatic q16_t qmul(q16_t a, q16_t b);
    logic signed [47:0] p;
    p = a * b + 48'sd32768;
    return p[39:16];
  endfunction

  function automatic entry_t to_entry(q16_t v);
    q16_t r;
    r = (v + 24'sd2) >>> 2;
    if (r > EntryMax) begin
      r = EntryMax;
    end else if (r < EntryMin) begin
      r = EntryMin;
    end
    return r[EntryW-1:0];
  endfunction

endpackage

FILE: rtl/arm_jacobian_from_joint_angles_unit.sv
// Jacobian of a six-axis stylus arm from five joint angles.
//
// Command channel: a transaction is taken at a rising edge with start_i high
// and busy_o low; angle_q0_i..angle_q4_i are signed Q3.13 radians.
// Result channel: six transactions per command, one per cycle, each marked by
// valid_o for one cycle. row_index_o counts 0..5 and last_row_o marks row 5.
// With transpose mode set each transaction carries a column of the Jacobian
// instead of a row.
// busy_o goes high after each accepted command and holds off the next one,
// so that commands are paced to the row emitter at the output.
// Sine and cosine come from one CORDIC stage per iteration, five lanes wide,
// followed by three product stages and one entry stage, all fully pipelined.
// Configuration: cfg_we_i writes register cfg_idx_i (0 upper link length,
// 1 lower link length, 2 transpose mode); write only while no command is in
// flight. Reset clears all pending work and restores the register defaults.
// The receiver cannot stall: every result is presented exactly once.
module arm_jacobian_from_joint_angles_unit import ajac_pkg::*; #(
  parameter int CORDIC_STEPS = CordicStepsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic signed [15:0]  angle_q0_i,
  input  logic signed [15:0]  angle_q1_i,
  input  logic signed [15:0]  angle_q2_i,
  input  logic signed [15:0]  angle_q3_i,
  input  logic signed [15:0]  angle_q4_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output logic                valid_o,
  output logic [2:0]          row_index_o,
  output entry_t              entry_0_o,
  output entry_t              entry_1_o,
  output entry_t              entry_2_o,
  output entry_t              entry_3_o,
  output entry_t              entry_4_o,
  output entry_t              entry_5_o,
  output logic                last_row_o
);

  localparam int Lat = CORDIC_STEPS + 6;

  logic [15:0] la_q, lb_q;
  logic        tr_q;
  logic [2:0]  gap_q;
  logic        accept;
  logic [Lat-1:0] vld_q;

  assign accept = start_i && !busy_o;
  assign busy_o = (gap_q != 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      la_q  <= UpperReset;
      lb_q  <= LowerReset;
      tr_q  <= 1'b0;
      gap_q <= 3'd0;
      vld_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegUpper:     la_q <= cfg_wdata_i;
          RegLower:     lb_q <= cfg_wdata_i;
          RegTranspose: tr_q <= cfg_wdata_i[0];
          default:      ;
        endcase
      end
      if (accept) begin
        gap_q <= 3'd5;
      end else if (gap_q != 3'd0) begin
        gap_q <= gap_q - 3'd1;
      end
      vld_q <= {vld_q[Lat-2:0], accept};
    end
  end

  q16_t s0, s1, s2, s3, s4, c0, c1, c2, c3, c4;

  ajac_cordic #(.Steps(CORDIC_STEPS)) u_cordic0 (
    .clk_i(clk_i), .angle_i(angle_q0_i), .sin_o(s0), .cos_o(c0));
  ajac_cordic #(.Steps(CORDIC_STEPS)) u_cordic1 (
    .clk_i(clk_i), .angle_i(angle_q1_i), .sin_o(s1), .cos_o(c1));
  ajac_cordic #(.Steps(CORDIC_STEPS)) u_cordic2 (
    .clk_i(clk_i), .angle_i(angle_q2_i), .sin_o(s2), .cos_o(c2));
  ajac_cordic #(.Steps(CORDIC_STEPS)) u_cordic3 (
    .clk_i(clk_i), .angle_i(angle_q3_i), .sin_o(s3), .cos_o(c3));
  ajac_cordic #(.Steps(CORDIC_STEPS)) u_cordic4 (
    .clk_i(clk_i), .angle_i(angle_q4_i), .sin_o(s4), .cos_o(c4));

  q16_t la, lb;
  assign la = {8'b0, la_q};
  assign lb = {8'b0, lb_q};

  // first products
  q16_t a_lac1_q, a_lbs2_q, a_las1_q, a_lbc2_q, a_lbs0_q, a_lbc0_q;
  q16_t a_s0s2_q, a_c0s2_q, a_s0c2_q, a_c0c2_q, a_c0c3_q, a_s0c3_q;
  q16_t a_s2s3_q, a_s2c3_q, a_c2s4_q, a_c0s3_q, a_s0s3_q;
  q16_t a_s0_q, a_c0_q, a_c2_q, a_s4_q, a_c4_q;

  always_ff @(posedge clk_i) begin
    a_lac1_q <= qmul(la, c1);
    a_lbs2_q <= qmul(lb, s2);
    a_las1_q <= qmul(la, s1);
    a_lbc2_q <= qmul(lb, c2);
    a_lbs0_q <= qmul(lb, s0);
    a_lbc0_q <= qmul(lb, c0);
    a_s0s2_q <= qmul(s0, s2);
    a_c0s2_q <= qmul(c0, s2);
    a_s0c2_q <= qmul(s0, c2);
    a_c0c2_q <= qmul(c0, c2);
    a_c0c3_q <= qmul(c0, c3);
    a_s0c3_q <= qmul(s0, c3);
    a_s2s3_q <= qmul(s2, s3);
    a_s2c3_q <= qmul(s2, c3);
    a_c2s4_q <= qmul(c2, s4);
    a_c0s3_q <= qmul(c0, s3);
    a_s0s3_q <= qmul(s0, s3);
    a_s0_q   <= s0;
    a_c0_q   <= c0;
    a_c2_q   <= c2;
    a_s4_q   <= s4;
    a_c4_q   <= c4;
  end

  q16_t s3_d1_q, c3_d1_q;
  always_ff @(posedge clk_i) begin
    s3_d1_q <= s3;
    c3_d1_q <= c3;
  end

  // second products and link sums
  q16_t b_p_q, b_r_q, b_m02_q, b_m22_q, b_s0c2s3_q, b_c0c2s3_q, b_s0c2c3_q;
  q16_t b_c0c2c3_q, b_s2c3c4_q, b_c0s3c4_q, b_s0s3c4_q, b_s0s2s4_q, b_c0s2s4_q;
  q16_t b_lbs2_q, b_s0_q, b_c0_q, b_c2_q, b_s0s2_q, b_c0s2_q, b_c0c3_q;
  q16_t b_s0c3_q, b_s2s3_q, b_c2s4_q, b_c4_q;

  always_ff @(posedge clk_i) begin
    b_p_q      <= a_lac1_q + a_lbs2_q;
    b_r_q      <= a_lbc2_q - a_las1_q;
    b_m02_q    <= qmul(a_lbs0_q, a_c2_q);
    b_m22_q    <= qmul(a_lbc0_q, a_c2_q);
    b_s0c2s3_q <= qmul(a_s0c2_q, s3_d1_q);
    b_c0c2s3_q <= qmul(a_c0c2_q, s3_d1_q);
    b_s0c2c3_q <= qmul(a_s0c2_q, c3_d1_q);
    b_c0c2c3_q <= qmul(a_c0c2_q, c3_d1_q);
    b_s2c3c4_q <= qmul(a_s2c3_q, a_c4_q);
    b_c0s3c4_q <= qmul(a_c0s3_q, a_c4_q);
    b_s0s3c4_q <= qmul(a_s0s3_q, a_c4_q);
    b_s0s2s4_q <= qmul(a_s0s2_q, a_s4_q);
    b_c0s2s4_q <= qmul(a_c0s2_q, a_s4_q);
    b_lbs2_q   <= a_lbs2_q;
    b_s0_q     <= a_s0_q;
    b_c0_q     <= a_c0_q;
    b_c2_q     <= a_c2_q;
    b_s0s2_q   <= a_s0s2_q;
    b_c0s2_q   <= a_c0s2_q;
    b_c0c3_q   <= a_c0c3_q;
    b_s0c3_q   <= a_s0c3_q;
    b_s2s3_q   <= a_s2s3_q;
    b_c2s4_q   <= a_c2s4_q;
    b_c4_q     <= a_c4_q;
  end

  // third products
  q16_t c_c0p_q, c_s0p_q, c_s0r_q, c_c0r_q, c_s0c2c3c4_q, c_c0c2c3c4_q;
  q16_t c_p_q, c_m02_q, c_m22_q, c_lbs2_q, c_s0_q, c_c0_q, c_c2_q;
  q16_t c_s0s2_q, c_c0s2_q, c_s0c2s3_q, c_c0c3_q, c_c0c2s3_q, c_s0c3_q;
  q16_t c_s2s3_q, c_s2c3c4_q, c_c2s4_q, c_c0s3c4_q, c_s0s2s4_q, c_s0s3c4_q;
  q16_t c_c0s2s4_q;

  always_ff @(posedge clk_i) begin
    c_c0p_q      <= qmul(b_c0_q, b_p_q);
    c_s0p_q      <= qmul(b_s0_q, b_p_q);
    c_s0r_q      <= qmul(b_s0_q, b_r_q);
    c_c0r_q      <= qmul(b_c0_q, b_r_q);
    c_s0c2c3c4_q <= qmul(b_s0c2c3_q, b_c4_q);
    c_c0c2c3c4_q <= qmul(b_c0c2c3_q, b_c4_q);
    c_p_q        <= b_p_q;
    c_m02_q      <= b_m02_q;
    c_m22_q      <= b_m22_q;
    c_lbs2_q     <= b_lbs2_q;
    c_s0_q       <= b_s0_q;
    c_c0_q       <= b_c0_q;
    c_c2_q       <= b_c2_q;
    c_s0s2_q     <= b_s0s2_q;
    c_c0s2_q     <= b_c0s2_q;
    c_s0c2s3_q   <= b_s0c2s3_q;
    c_c0c3_q     <= b_c0c3_q;
    c_c0c2s3_q   <= b_c0c2s3_q;
    c_s0c3_q     <= b_s0c3_q;
    c_s2s3_q     <= b_s2s3_q;
    c_s2c3c4_q   <= b_s2c3c4_q;
    c_c2s4_q     <= b_c2s4_q;
    c_c0s3c4_q   <= b_c0s3c4_q;
    c_s0s2s4_q   <= b_s0s2s4_q;
    c_s0s3c4_q   <= b_s0s3c4_q;
    c_c0s2s4_q   <= b_c0s2s4_q;
  end

  // matrix assembly
  q16_t   m_d [6][6];
  entry_t mat_q [6][6];
  logic   mat_we, mat_new;

  assign mat_we  = vld_q[Lat-2];
  assign mat_new = vld_q[Lat-1];

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      for (int n = 0; n < 6; n++) begin
        m_d[k][n] = '0;
      end
    end
    m_d[0][0] = c_c0p_q;
    m_d[2][0] = -c_s0p_q;
    m_d[0][1] = c_s0r_q;
    m_d[1][1] = c_p_q;
    m_d[2][1] = c_c0r_q;
    m_d[0][2] = c_m02_q;
    m_d[1][2] = c_lbs2_q;
    m_d[2][2] = c_m22_q;
    m_d[4][0] = QOne;
    m_d[3][1] = -c_c0_q;
    m_d[5][1] = c_s0_q;
    m_d[3][2] = -c_c0_q;
    m_d[5][2] = c_s0_q;
    m_d[3][3] = c_s0s2_q;
    m_d[4][3] = -c_c2_q;
    m_d[5][3] = c_c0s2_q;
    m_d[3][4] = -c_s0c2s3_q - c_c0c3_q;
    m_d[4][4] = -c_s2s3_q;
    m_d[5][4] = -c_c0c2s3_q + c_s0c3_q;
    m_d[3][5] = c_s0c2c3c4_q - c_c0s3c4_q - c_s0s2s4_q;
    m_d[4][5] = c_s2c3c4_q + c_c2s4_q;
    m_d[5][5] = c_c0c2c3c4_q + c_s0s3c4_q - c_c0s2s4_q;
  end

  // row emitter
  logic       act_q, emit;
  logic [2:0] cnt_q, idx;
  entry_t     ent_d [6];
  logic       valid_q, last_q;
  logic [2:0] row_q;
  entry_t     ent_q [6];

  assign emit = mat_new || act_q;
  assign idx  = mat_new ? 3'd0 : cnt_q;

  // rows shift toward slot 0 as they are emitted
  always_ff @(posedge clk_i) begin
    if (mat_we) begin
      for (int k = 0; k < 6; k++) begin
        for (int n = 0; n < 6; n++) begin
          mat_q[k][n] <= to_entry(tr_q ? m_d[n][k] : m_d[k][n]);
        end
      end
    end else if (emit) begin
      for (int k = 0; k < 5; k++) begin
        for (int n = 0; n < 6; n++) begin
          mat_q[k][n] <= mat_q[k+1][n];
        end
      end
    end
  end

  always_comb begin
    for (int n = 0; n < 6; n++) begin
      ent_d[n] = mat_q[0][n];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q   <= 1'b0;
      cnt_q   <= 3'd0;
      valid_q <= 1'b0;
      row_q   <= 3'd0;
      last_q  <= 1'b0;
    end else begin
      valid_q <= emit;
      row_q   <= idx;
      last_q  <= emit && (idx == 3'd5);
      if (mat_new) begin
        act_q <= 1'b1;
        cnt_q <= 3'd1;
      end else if (act_q) begin
        if (cnt_q == 3'd5) begin
          act_q <= 1'b0;
          cnt_q <= 3'd0;
        end else begin
          cnt_q <= cnt_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int n = 0; n < 6; n++) begin
      ent_q[n] <= ent_d[n];
    end
  end

  assign valid_o     = valid_q;
  assign row_index_o = row_q;
  assign last_row_o  = last_q;
  assign entry_0_o   = ent_q[0];
  assign entry_1_o   = ent_q[1];
  assign entry_2_o   = ent_q[2];
  assign entry_3_o   = ent_q[3];
  assign entry_4_o   = ent_q[4];
  assign entry_5_o   = ent_q[5];

`ifndef ASSERT_OFF
  a_busy_after_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("busy not raised after command");
  a_last_matches_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (last_row_o == (row_index_o == 3'd5)))
    else $error("last row flag mismatch");
  a_rows_in_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_row_o |=> valid_o && (row_index_o == $past(row_index_o) + 3'd1))
    else $error("rows not consecutive");
  a_row_zero_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(valid_o) |-> (row_index_o == 3'd0))
    else $error("burst did not start at row zero");
`endif

endmodule

FILE: rtl/ajac_cordic.sv
module ajac_cordic import ajac_pkg::*; #(
  parameter int Steps = CordicStepsDef
) (
  input  logic               clk_i,
  input  logic signed [15:0] angle_i,
  output q16_t               sin_o,
  output q16_t               cos_o
);

  logic signed [CordicW-1:0] z_in, z_fold;
  logic                      flip_fold;
  logic signed [CordicW-1:0] x_q [Steps+1];
  logic signed [CordicW-1:0] y_q [Steps+1];
  logic signed [CordicW-1:0] z_q [Steps+1];
  logic                      flip_q [Steps+1];
  logic signed [CordicW-1:0] xr, yr;
  q16_t                      sin_q, cos_q;

  // fold into +-pi/2
  always_comb begin
    z_in = {angle_i[15], angle_i, 17'b0};
    z_fold = z_in;
    flip_fold = 1'b0;
    if (z_in > Q30HalfPi) begin
      z_fold = z_in - Q30Pi;
      flip_fold = 1'b1;
    end else if (z_in < -Q30HalfPi) begin
      z_fold = z_in + Q30Pi;
      flip_fold = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0]    <= CordicGain;
    y_q[0]    <= '0;
    z_q[0]    <= z_fold;
    flip_q[0] <= flip_fold;
  end

  for (genvar i = 0; i < Steps; i++) begin : g_step
    logic signed [CordicW-1:0] atan_c, x_d, y_d, z_d;
    assign atan_c = {4'b0, AtanTab[i]};
    always_comb begin
      if (z_q[i] >= 0) begin
        x_d = x_q[i] - (y_q[i] >>> i);
        y_d = y_q[i] + (x_q[i] >>> i);
        z_d = z_q[i] - atan_c;
      end else begin
        x_d = x_q[i] + (y_q[i] >>> i);
        y_d = y_q[i] - (x_q[i] >>> i);
        z_d = z_q[i] + atan_c;
      end
    end
    always_ff @(posedge clk_i) begin
      x_q[i+1]    <= x_d;
      y_q[i+1]    <= y_d;
      z_q[i+1]    <= z_d;
      flip_q[i+1] <= flip_q[i];
    end
  end

  assign xr = (x_q[Steps] + 34'sd8192) >>> 14;
  assign yr = (y_q[Steps] + 34'sd8192) >>> 14;

  always_ff @(posedge clk_i) begin
    cos_q <= flip_q[Steps] ? -xr[23:0] : xr[23:0];
    sin_q <= flip_q[Steps] ? -yr[23:0] : yr[23:0];
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule
